[rtl/core/gma_pkg.sv]
// Package for the gated moving average block.
// Holds widths, register reset values, shared types and state codes.
// No dependencies; every other file of the block uses it.
package gma_pkg;

    // Field widths
    localparam int SAMPLE_W    = 12;
    localparam int CFG_W       = 12;
    localparam int FILL_OUT_W  = 5;
    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 32;

    // Default window length, samples
    localparam int WINDOW_LEN_DEF = 20;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Register reset values
    localparam logic [CFG_W-1:0] LOW_RST  = CFG_W'(480);
    localparam logic [CFG_W-1:0] HIGH_RST = CFG_W'(3200);
    localparam logic [CFG_W-1:0] JUMP_RST = CFG_W'(480);

    // Register indexes (byte address / 4)
    typedef enum logic [1:0] {
        REG_LOW  = 2'd0,
        REG_HIGH = 2'd1,
        REG_JUMP = 2'd2
    } t_reg_idx;

    // Current limits, handed to the front
    typedef struct packed {
        logic [CFG_W-1:0] low;
        logic [CFG_W-1:0] high;
        logic [CFG_W-1:0] jump;
    } t_limits;

    // Classified sample, front to back
    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                take;
        logic                clear;
    } t_cmd;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_DIV,
        ST_DONE
    } t_state;

endpackage

[rtl/core/gated_moving_average.sv]
// Gated moving average: limit registers, front classifier, queue, back end.
// An accepted sample's word passes the queue, ST_READ, ST_UPDATE, the serial sum/fill
// divider (ST_DIV) and ST_DONE before it is offered; a rejected one skips to ST_DONE.
// One sample at a time: the next leaves the queue once the last word is registered.
// Reset (synchronous, i_rst_n low): limits to defaults, window empty, average
// zero; the ring storage itself is not cleared. Depends on gma_pkg and submodules.
module gated_moving_average #(
    parameter int WINDOW_LEN = gma_pkg::WINDOW_LEN_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // sample channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [gma_pkg::SAMPLE_W-1:0]    i_sample_in,
    // result channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [gma_pkg::SAMPLE_W-1:0]    o_average_out,
    output logic                            o_accepted,
    output logic [gma_pkg::FILL_OUT_W-1:0]  o_window_fill,
    // register port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [gma_pkg::ADDR_W-1:0]      paddr,
    input  logic [gma_pkg::DATA_W-1:0]      pwdata,
    output logic [gma_pkg::DATA_W-1:0]      prdata,
    output logic                            pready
);

    gma_pkg::t_limits  r_lim;
    gma_pkg::t_reg_idx reg_idx;
    gma_pkg::t_cmd     push_cmd;
    gma_pkg::t_cmd     pop_cmd;
    logic              push;
    logic              pop;
    logic              q_full;
    logic              q_empty;
    logic              wr_en;

    assign pready  = 1'b1;
    assign reg_idx = gma_pkg::t_reg_idx'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    // Limit registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim.low  <= gma_pkg::LOW_RST;
            r_lim.high <= gma_pkg::HIGH_RST;
            r_lim.jump <= gma_pkg::JUMP_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                gma_pkg::REG_LOW:  r_lim.low  <= pwdata[gma_pkg::CFG_W-1:0];
                gma_pkg::REG_HIGH: r_lim.high <= pwdata[gma_pkg::CFG_W-1:0];
                gma_pkg::REG_JUMP: r_lim.jump <= pwdata[gma_pkg::CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb begin
        unique case (reg_idx)
            gma_pkg::REG_LOW:  prdata = gma_pkg::DATA_W'(r_lim.low);
            gma_pkg::REG_HIGH: prdata = gma_pkg::DATA_W'(r_lim.high);
            gma_pkg::REG_JUMP: prdata = gma_pkg::DATA_W'(r_lim.jump);
            default:           prdata = '0;
        endcase
    end

    gma_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_limits    (r_lim),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_sample_in (i_sample_in),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    gma_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_cmd   (pop_cmd),
        .o_empty (q_empty)
    );

    gma_back #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (pop_cmd),
        .i_q_empty     (q_empty),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_average_out (o_average_out),
        .o_accepted    (o_accepted),
        .o_window_fill (o_window_fill)
    );

endmodule

[rtl/core/gma_fifo.sv]
// Short queue of classified samples between front and back.
// Depends on gma_pkg (t_cmd, QUEUE_DEPTH).
module gma_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  gma_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output gma_pkg::t_cmd o_cmd,
    output logic          o_empty
);

    localparam int QW = (gma_pkg::QUEUE_DEPTH > 1) ? $clog2(gma_pkg::QUEUE_DEPTH) : 1;

    gma_pkg::t_cmd r_mem [gma_pkg::QUEUE_DEPTH];
    logic [QW-1:0] r_wr;
    logic [QW-1:0] r_rd;
    logic [QW:0]   r_cnt;
    logic          push_ok;
    logic          pop_ok;

    assign o_full  = (r_cnt == (QW+1)'(gma_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rd];

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    // Pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_wr <= (r_wr == QW'(gma_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop_ok) begin
                r_rd <= (r_rd == QW'(gma_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({push_ok, pop_ok})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

[rtl/core/gma_front.sv]
// Front end: takes sample words, gates them against the limits and
// the previous sample, and queues the verdict. Depends on gma_pkg.
module gma_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  gma_pkg::t_limits              i_limits,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [gma_pkg::SAMPLE_W-1:0]  i_sample_in,
    input  logic                          i_q_full,
    output logic                          o_push,
    output gma_pkg::t_cmd                 o_cmd
);

    logic [gma_pkg::SAMPLE_W-1:0] r_prev;
    logic [gma_pkg::SAMPLE_W-1:0] n_prev;
    logic [gma_pkg::SAMPLE_W-1:0] diff;
    logic                         accept;

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;
    assign o_push     = accept;

    // Classify against limits and jump from previous sample
    always_comb begin
        diff = (i_sample_in >= r_prev) ? (i_sample_in - r_prev) : (r_prev - i_sample_in);
        o_cmd.sample = i_sample_in;
        o_cmd.take   = (i_sample_in > i_limits.low) && (i_sample_in < i_limits.high)
                       && (diff < i_limits.jump);
        // zero after zero empties the window
        o_cmd.clear  = (r_prev == '0) && (i_sample_in == '0);
        n_prev       = accept ? i_sample_in : r_prev;
    end

    // Previous sample, updated on every accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
        end else begin
            r_prev <= n_prev;
        end
    end

endmodule

[rtl/core/gma_back.sv]
// Back end: window ring, running sum, serial divider and output register.
// Depends on gma_pkg (t_cmd, t_state, widths).
module gma_back #(
    parameter int WINDOW_LEN = gma_pkg::WINDOW_LEN_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  gma_pkg::t_cmd                   i_cmd,
    input  logic                            i_q_empty,
    output logic                            o_pop,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [gma_pkg::SAMPLE_W-1:0]    o_average_out,
    output logic                            o_accepted,
    output logic [gma_pkg::FILL_OUT_W-1:0]  o_window_fill
);

    localparam int SW   = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int FW   = $clog2(WINDOW_LEN + 1);
    localparam int SUMW = gma_pkg::SAMPLE_W + FW;
    localparam int CW   = $clog2(SUMW);

    // Window ring storage
    logic [gma_pkg::SAMPLE_W-1:0] r_win [WINDOW_LEN];
    logic [gma_pkg::SAMPLE_W-1:0] r_old;

    gma_pkg::t_state              r_state, n_state;
    logic [gma_pkg::SAMPLE_W-1:0] r_sample, n_sample;
    logic                         r_acc, n_acc;
    logic [SW-1:0]                r_slot, n_slot;
    logic [FW-1:0]                r_fill, n_fill;
    logic [SUMW-1:0]              r_sum, n_sum;
    logic [gma_pkg::SAMPLE_W-1:0] r_held, n_held;
    logic [SUMW-1:0]              r_q, n_q;
    logic [FW-1:0]                r_rem, n_rem;
    logic [CW-1:0]                r_cnt, n_cnt;
    logic                         r_ovalid, n_ovalid;
    logic [gma_pkg::SAMPLE_W-1:0] r_oavg, n_oavg;
    logic                         r_oacc, n_oacc;
    logic [gma_pkg::FILL_OUT_W-1:0] r_ofill, n_ofill;

    logic [SUMW-1:0] sum_upd;
    logic [FW:0]     trial;
    logic            ge;
    logic [SUMW-1:0] q_step;
    logic            out_free;

    assign o_out_valid   = r_ovalid;
    assign o_average_out = r_oavg;
    assign o_accepted    = r_oacc;
    assign o_window_fill = r_ofill;

    // Ring read (registered) and write
    always_ff @(posedge i_clk) begin
        if (r_state == gma_pkg::ST_READ) begin
            r_old <= r_win[r_slot];
        end
        if (r_state == gma_pkg::ST_UPDATE) begin
            r_win[r_slot] <= r_sample;
        end
    end

    // Sequencer
    always_comb begin
        n_state  = r_state;
        n_sample = r_sample;
        n_acc    = r_acc;
        n_slot   = r_slot;
        n_fill   = r_fill;
        n_sum    = r_sum;
        n_held   = r_held;
        n_q      = r_q;
        n_rem    = r_rem;
        n_cnt    = r_cnt;
        n_ovalid = r_ovalid;
        n_oavg   = r_oavg;
        n_oacc   = r_oacc;
        n_ofill  = r_ofill;
        o_pop    = 1'b0;
        sum_upd  = r_sum;

        // one restoring divide step
        trial  = {r_rem, r_q[SUMW-1]};
        ge     = (trial >= {1'b0, r_fill});
        q_step = {r_q[SUMW-2:0], ge};

        out_free = !r_ovalid || !i_out_stall;
        if (r_ovalid && !i_out_stall) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            gma_pkg::ST_IDLE: begin
                if (!i_q_empty) begin
                    o_pop    = 1'b1;
                    n_sample = i_cmd.sample;
                    n_acc    = i_cmd.take;
                    if (i_cmd.clear) begin
                        n_fill  = '0;
                        n_slot  = '0;
                        n_sum   = '0;
                        n_held  = '0;
                        n_state = gma_pkg::ST_DONE;
                    end else if (i_cmd.take) begin
                        n_state = gma_pkg::ST_READ;
                    end else begin
                        n_state = gma_pkg::ST_DONE;
                    end
                end
            end
            gma_pkg::ST_READ: begin
                n_state = gma_pkg::ST_UPDATE;
            end
            gma_pkg::ST_UPDATE: begin
                // evict the oldest once full, else grow
                if (r_fill == FW'(WINDOW_LEN)) begin
                    sum_upd = r_sum - SUMW'(r_old) + SUMW'(r_sample);
                end else begin
                    n_fill  = r_fill + 1'b1;
                    sum_upd = r_sum + SUMW'(r_sample);
                end
                n_sum   = sum_upd;
                n_slot  = (r_slot == SW'(WINDOW_LEN - 1)) ? '0 : r_slot + 1'b1;
                n_q     = sum_upd;
                n_rem   = '0;
                n_cnt   = CW'(SUMW - 1);
                n_state = gma_pkg::ST_DIV;
            end
            gma_pkg::ST_DIV: begin
                n_rem = ge ? FW'(trial - {1'b0, r_fill}) : trial[FW-1:0];
                n_q   = q_step;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_held  = q_step[gma_pkg::SAMPLE_W-1:0];
                    n_state = gma_pkg::ST_DONE;
                end
            end
            gma_pkg::ST_DONE: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_oavg   = r_held;
                    n_oacc   = r_acc;
                    n_ofill  = gma_pkg::FILL_OUT_W'(32'(r_fill));
                    n_state  = gma_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = gma_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= gma_pkg::ST_IDLE;
            r_ovalid <= 1'b0;
            r_slot   <= '0;
            r_fill   <= '0;
            r_sum    <= '0;
            r_held   <= '0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_slot   <= n_slot;
            r_fill   <= n_fill;
            r_sum    <= n_sum;
            r_held   <= n_held;
        end
    end

    // Working and output payload
    always_ff @(posedge i_clk) begin
        r_sample <= n_sample;
        r_acc    <= n_acc;
        r_q      <= n_q;
        r_rem    <= n_rem;
        r_cnt    <= n_cnt;
        r_oavg   <= n_oavg;
        r_oacc   <= n_oacc;
        r_ofill  <= n_ofill;
    end

endmodule

[rtl/core/gma_checker.sv]
// Port-level checks for the gated moving average, bound to the top level.
// Depends on gma_pkg and on gated_moving_average's port list.
module gma_checker #(
    parameter int WINDOW_LEN = gma_pkg::WINDOW_LEN_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            o_out_valid,
    input  logic                            i_out_stall,
    input  logic [gma_pkg::SAMPLE_W-1:0]    o_average_out,
    input  logic                            o_accepted,
    input  logic [gma_pkg::FILL_OUT_W-1:0]  o_window_fill,
    input  logic                            pready
);

    // A stalled result word stays offered
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result valid dropped while stalled");

    // A stalled result word keeps its fields
    a_word_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_average_out) && $stable(o_accepted)
            && $stable(o_window_fill))
        else $error("result fields changed while stalled");

    // Reported fill never exceeds the window
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> 32'(o_window_fill) <= WINDOW_LEN)
        else $error("window fill above window length");

    // Register port never inserts wait states
    a_no_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("register port not ready");

endmodule

bind gated_moving_average gma_checker #(
    .WINDOW_LEN (WINDOW_LEN)
) u_gma_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_average_out (o_average_out),
    .o_accepted    (o_accepted),
    .o_window_fill (o_window_fill),
    .pready        (pready)
);

[verif/tb_top.sv]
// Self-checking bench for gated_moving_average: sample driver, result monitor,
// register writes over the APB port and an in-bench model of the gated window.
// Depends on gma_pkg and the gated_moving_average RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIN          = gma_pkg::WINDOW_LEN_DEF;
    localparam int SETTLE_CYC   = 40;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int IDLE_PCT     = 20;

    // One result word as the block reports it
    typedef struct {
        logic [gma_pkg::SAMPLE_W-1:0]   average;
        logic                           accepted;
        logic [gma_pkg::FILL_OUT_W-1:0] fill;
    } t_avg_word;

    // One pending sample; drain_first holds it back until all results are in
    typedef struct {
        logic [gma_pkg::SAMPLE_W-1:0] sample;
        logic                         drain_first;
    } t_sample_item;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_in_valid = 1'b0;
    logic                           o_in_stall;
    logic [gma_pkg::SAMPLE_W-1:0]   i_sample_in = '0;
    logic                           o_out_valid;
    logic                           i_out_stall = 1'b0;
    logic [gma_pkg::SAMPLE_W-1:0]   o_average_out;
    logic                           o_accepted;
    logic [gma_pkg::FILL_OUT_W-1:0] o_window_fill;
    logic                           psel = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite = 1'b0;
    logic [gma_pkg::ADDR_W-1:0]     paddr = '0;
    logic [gma_pkg::DATA_W-1:0]     pwdata = '0;
    logic [gma_pkg::DATA_W-1:0]     prdata;
    logic                           pready;

    gated_moving_average dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_sample_in   (i_sample_in),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_average_out (o_average_out),
        .o_accepted    (o_accepted),
        .o_window_fill (o_window_fill),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Shared bench state
    t_sample_item sample_backlog[$];
    t_avg_word    expected_words[$];
    int           words_queued  = 0;
    int           words_checked = 0;
    int           fail_count    = 0;
    int           cycle_count   = 0;
    logic         no_idle       = 1'b0;
    int           last_gen      = 0;

    // Model state: limits, ring window, sum, previous sample, held average
    logic [gma_pkg::CFG_W-1:0]    lim_low  = gma_pkg::LOW_RST;
    logic [gma_pkg::CFG_W-1:0]    lim_high = gma_pkg::HIGH_RST;
    logic [gma_pkg::CFG_W-1:0]    lim_jump = gma_pkg::JUMP_RST;
    logic [gma_pkg::SAMPLE_W-1:0] ring [WIN];
    int                           ring_slot = 0;
    int                           ring_fill = 0;
    int                           ring_sum  = 0;
    logic [gma_pkg::SAMPLE_W-1:0] prev_sample = '0;
    logic [gma_pkg::SAMPLE_W-1:0] held_avg    = '0;

    // Gate one sample, update the window and return the word it causes
    function automatic t_avg_word step_average(input logic [gma_pkg::SAMPLE_W-1:0] s);
        logic [gma_pkg::SAMPLE_W-1:0] gap;
        logic                         take;
        t_avg_word                    w;
        gap  = (s >= prev_sample) ? s - prev_sample : prev_sample - s;
        take = (s > lim_low) && (s < lim_high) && (gap < lim_jump);
        if (take) begin
            if (ring_fill >= WIN) begin
                ring_sum -= ring[ring_slot];
            end else begin
                ring_fill++;
            end
            ring[ring_slot] = s;
            ring_sum += s;
            ring_slot = (ring_slot + 1 >= WIN) ? 0 : ring_slot + 1;
            held_avg = gma_pkg::SAMPLE_W'(ring_sum / ring_fill);
        end
        // zero after zero empties the window
        if (prev_sample == '0 && s == '0) begin
            held_avg  = '0;
            ring_fill = 0;
            ring_slot = 0;
            ring_sum  = 0;
        end
        prev_sample = s;
        w.average  = held_avg;
        w.accepted = take;
        w.fill     = gma_pkg::FILL_OUT_W'(ring_fill);
        return w;
    endfunction

    function automatic int clamp_sample(input int v);
        return (v < 0) ? 0 : (v > 4095) ? 4095 : v;
    endfunction

    function automatic void queue_sample(input int s, input logic drain);
        t_sample_item it;
        it.sample      = gma_pkg::SAMPLE_W'(s);
        it.drain_first = drain;
        sample_backlog = {sample_backlog, it};
        words_queued++;
        last_gen = s;
    endfunction

    // Mostly walks that stay inside the limits, plus zeros, edges and noise
    function automatic void queue_phase(input int lo, input int hi, input int jmp,
                                        input int count);
        int r;
        int v;
        int span;
        logic drain;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            drain = ($urandom_range(0, 49) == 0) || (n == 40);
            if (r < 70) begin
                span = (jmp > 1) ? jmp - 1 : 0;
                v = last_gen + $urandom_range(0, 2 * span) - span;
                if (lo + 1 <= hi - 1) begin
                    v = (v < lo + 1) ? lo + 1 : (v > hi - 1) ? hi - 1 : v;
                end else begin
                    v = $urandom_range(0, 4095);
                end
                queue_sample(clamp_sample(v), drain);
            end else if (r < 80) begin
                queue_sample(0, drain);
                if ($urandom_range(0, 1) == 1) queue_sample(0, 1'b0);
            end else if (r < 88) begin
                case ($urandom_range(0, 6))
                    0: v = lo;
                    1: v = hi;
                    2: v = lo + 1;
                    3: v = hi - 1;
                    4: v = last_gen + jmp;
                    5: v = last_gen - jmp;
                    default: v = last_gen + jmp - 1;
                endcase
                queue_sample(clamp_sample(v), drain);
            end else begin
                queue_sample($urandom_range(0, 4095), drain);
            end
        end
    endfunction

    // Register write then read back, both over APB
    task automatic write_reg(input gma_pkg::t_reg_idx idx,
                             input logic [gma_pkg::CFG_W-1:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= gma_pkg::ADDR_W'(int'(idx) * 4);
        pwdata  <= gma_pkg::DATA_W'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            gma_pkg::REG_LOW:  lim_low  = val;
            gma_pkg::REG_HIGH: lim_high = val;
            default:           lim_jump = val;
        endcase
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        if (prdata !== gma_pkg::DATA_W'(val)) begin
            $error("register %s: expected %0d, got %0d", idx.name(), val, prdata);
            fail_count++;
        end
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Wait until every queued sample has had its word, then let the block settle
    task automatic wait_drained();
        while (words_checked < words_queued) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic run_phase(input int lo, input int hi, input int jmp, input int count,
                             input logic steady);
        wait_drained();
        write_reg(gma_pkg::REG_LOW, gma_pkg::CFG_W'(lo));
        write_reg(gma_pkg::REG_HIGH, gma_pkg::CFG_W'(hi));
        write_reg(gma_pkg::REG_JUMP, gma_pkg::CFG_W'(jmp));
        no_idle = steady;
        queue_phase(lo, hi, jmp, count);
    endtask

    // Stimulus: directed opening at reset limits, then random phases
    initial begin : stimulus
        int opening[];
        int lo;
        int hi;
        opening = {0, 4095, 0, 0, 479, 481, 480,
                   900, 1300, 1700, 2100, 2500, 2900, 3199, 3200,
                   3000, 2600, 2200, 1800, 1400, 1000, 600,
                   1000, 1400, 1800, 2200, 2600, 3000, 2520, 0, 0};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (opening[k]) queue_sample(opening[k], 1'b0);

        run_phase(0, 4095, 4095, 110, 1'b0);
        run_phase(480, 3200, 480, 110, 1'b1);
        run_phase(4095, 0, 100, 60, 1'b0);
        run_phase(1000, 1000, 4095, 40, 1'b0);
        run_phase(200, 3800, 0, 60, 1'b0);
        run_phase(1, 4094, 1, 60, 1'b0);
        for (int p = 0; p < 4; p++) begin
            lo = $urandom_range(0, 2500);
            hi = $urandom_range(lo + 200, 4095);
            run_phase(lo, hi, $urandom_range(1, 1500), 110, 1'b0);
        end
        wait_drained();

        if (expected_words.size() != 0) begin
            $error("%0d result words never arrived", expected_words.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("gated_moving_average: match");
        end else begin
            $display("gated_moving_average: mismatch");
        end
        $finish;
    end

    // Sample driver: holds each word until taken, predicts at acceptance
    always @(posedge i_clk) begin : sample_driver
        logic         take_now;
        logic         can_send;
        t_sample_item nxt;
        t_avg_word    pred;
        take_now = i_in_valid && !o_in_stall;
        if (i_rst_n && take_now) begin
            pred = step_average(i_sample_in);
            expected_words = {expected_words, pred};
        end
        can_send = (sample_backlog.size() != 0)
                && !(sample_backlog[0].drain_first && expected_words.size() != 0)
                && (no_idle || $urandom_range(0, 99) >= IDLE_PCT);
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || take_now) begin
            if (can_send) begin
                nxt = sample_backlog.pop_front();
                i_in_valid  <= 1'b1;
                i_sample_in <= nxt.sample;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Result monitor: compare each taken word with the oldest prediction
    always @(posedge i_clk) begin : result_monitor
        t_avg_word want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                words_checked++;
                if (expected_words.size() == 0) begin
                    $error("unexpected result word: average %0d accepted %0d fill %0d",
                           o_average_out, o_accepted, o_window_fill);
                    fail_count++;
                end else begin
                    want = expected_words.pop_front();
                    if (o_average_out !== want.average) begin
                        $error("average_out: expected %0d, got %0d",
                               want.average, o_average_out);
                        fail_count++;
                    end
                    if (o_accepted !== want.accepted) begin
                        $error("accepted: expected %0d, got %0d", want.accepted, o_accepted);
                        fail_count++;
                    end
                    if (o_window_fill !== want.fill) begin
                        $error("window_fill: expected %0d, got %0d", want.fill, o_window_fill);
                        fail_count++;
                    end
                end
            end
            i_out_stall <= no_idle ? 1'b0 : ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("gated_moving_average: mismatch");
            $finish;
        end
    end

endmodule
